>>> rtl/core/recycling_random_ring_assert.svh
// Assertion macros used by the recycling random ring RTL.
`ifndef RECYCLING_RANDOM_RING_ASSERT_SVH
`define RECYCLING_RANDOM_RING_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RRR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RRR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/rrr_pkg.sv
// Shared widths, codes and types of the recycling random ring.
package rrr_pkg;

   localparam int ACTION_W  = 2;
   localparam int VALUE_W   = 32;
   localparam int SLOT_W    = 10;
   localparam int SIZE_W    = 11;
   localparam int STRIDE_W  = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   // Largest ring size that the size register can express.
   localparam int SIZE_MAX = (2 ** SIZE_W) - 1;

   localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DRAW    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_STRIDE = 2'd1;

   localparam logic [SIZE_W-1:0]   RING_SIZE_RESET      = 11'd1024;
   localparam logic [STRIDE_W-1:0] REPLACE_STRIDE_RESET = 10'd1;

   // Status of the remainder unit as seen by the control logic.
   typedef struct packed {
      logic busy;
      logic done;
   } rrr_mod_status_type;

endpackage

>>> rtl/core/recycling_random_ring.sv
// Top level of the recycling random ring: control, pointers and the ring store.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  action, fresh_value, slot_index
//   rsp      out        rsp_valid/rsp_stall  value, refreshed
//   csr      in         csr_valid/csr_ready  index, data
//
// A load, or an unused action, leaves the control idle. A draw that does not refresh
// its slot reads the ring RAM and then hands the word to the result register. A
// refreshing draw hands over the fresh word and then, like a restart, waits for
// the remainder unit, which reduces the replace pointer or the restart index
// modulo the ring size one bit per cycle.
// Reset is synchronous and clears the cursor to zero, the replace pointer to
// one and the registers to their defaults; the ring RAM itself is not cleared.
// The block takes a new item while a finished result is still held by a stall
// on the result side; only a following draw waits for that result to leave.
`include "recycling_random_ring_assert.svh"

module recycling_random_ring #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rrr_pkg::ACTION_W-1:0]    req_action,
   input  logic [rrr_pkg::VALUE_W-1:0]     req_fresh_value,
   input  logic [rrr_pkg::SLOT_W-1:0]      req_slot_index,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrr_pkg::VALUE_W-1:0]     rsp_value,
   output logic                            rsp_refreshed,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rrr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrr_pkg::CSR_DATA_W-1:0]  csr_data
);

   import rrr_pkg::*;

   // The usable ring is bounded both by the storage and by the size register.
   localparam int EFF_MAX = (RING_DEPTH < SIZE_MAX) ? RING_DEPTH : SIZE_MAX;
   localparam int PTR_W   = $clog2(EFF_MAX);
   localparam int NW      = $clog2(EFF_MAX + 1);
   localparam int WIDE_W  = (PTR_W > STRIDE_W) ? PTR_W : STRIDE_W;
   // Wide enough for a pointer plus a stride, and for a slot index.
   localparam int SUM_W   = ((WIDE_W > SLOT_W) ? WIDE_W : SLOT_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD,
      ST_MOD
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     cursor_ff, cursor_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [SIZE_W-1:0]    ring_size_ff, ring_size_in;
   logic [STRIDE_W-1:0]  stride_ff, stride_in;
   logic                 refresh_ff, refresh_in;
   logic                 mod_restart_ff, mod_restart_in;
   logic [VALUE_W-1:0]   fresh_ff, fresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_refreshed_ff, rsp_refreshed_in;

   logic [NW-1:0]        n_eff;
   logic [SUM_W-1:0]     n_ext;
   logic [PTR_W-1:0]     cursor_eff;
   logic [SUM_W-1:0]     cursor_step;
   logic [PTR_W-1:0]     cursor_after_draw;
   logic [SUM_W-1:0]     slot_ext;
   logic                 load_ok;
   logic                 hit;
   logic                 accept;
   logic                 rsp_free;

   logic                 ram_wr_en;
   logic [PTR_W-1:0]     ram_wr_addr;
   logic                 ram_rd_en;
   logic [VALUE_W-1:0]   ram_rd_data;

   logic                 mod_start;
   logic [SUM_W-1:0]     mod_dividend;
   rrr_mod_status_type   mod_status;
   logic [SUM_W-1:0]     mod_rem;

   // A size of zero behaves as one; a size beyond the storage is clipped.
   always_comb begin
      if (ring_size_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(ring_size_ff) > 32'(EFF_MAX)) begin
         n_eff = NW'(EFF_MAX);
      end else begin
         n_eff = NW'(ring_size_ff);
      end
   end

   assign n_ext = SUM_W'(n_eff);

   // A cursor left beyond a shrunken ring wraps to zero before a draw uses it.
   assign cursor_eff        = (SUM_W'(cursor_ff) >= n_ext) ? '0 : cursor_ff;
   assign cursor_step       = SUM_W'(cursor_eff) + SUM_W'(1);
   assign cursor_after_draw = (cursor_step >= n_ext) ? '0 : cursor_step[PTR_W-1:0];
   assign hit               = cursor_eff == ptr_ff;

   assign slot_ext = SUM_W'(req_slot_index);
   assign load_ok  = slot_ext < n_ext;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // A refreshing draw writes the fresh word and returns it from a register,
   // so the RAM never sees a read and a write of the same slot together.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_eff;
      ram_rd_en   = 1'b0;
      if (accept) begin
         case (req_action)
            ACT_LOAD: begin
               ram_wr_en   = load_ok;
               ram_wr_addr = slot_ext[PTR_W-1:0];
            end
            ACT_DRAW: begin
               ram_wr_en = hit;
               ram_rd_en = !hit;
            end
            default: begin
            end
         endcase
      end
   end

   // The remainder unit reduces either the restart index or the advanced
   // replace pointer modulo the ring size that holds at the start.
   assign mod_start = accept && (((req_action == ACT_DRAW) && hit) ||
                                 (req_action == ACT_RESTART));
   assign mod_dividend = (req_action == ACT_RESTART) ? slot_ext :
                         (SUM_W'(ptr_ff) + SUM_W'(stride_ff));

   always_comb begin
      state_in         = state_ff;
      cursor_in        = cursor_ff;
      ptr_in           = ptr_ff;
      refresh_in       = refresh_ff;
      mod_restart_in   = mod_restart_ff;
      fresh_in         = accept ? req_fresh_value : fresh_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_value_in     = rsp_value_ff;
      rsp_refreshed_in = rsp_refreshed_ff;
      ring_size_in     = ring_size_ff;
      stride_in        = stride_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RING_SIZE:      ring_size_in = csr_data[SIZE_W-1:0];
            CSR_REPLACE_STRIDE: stride_in    = csr_data[STRIDE_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_DRAW: begin
                     cursor_in      = cursor_after_draw;
                     refresh_in     = hit;
                     mod_restart_in = 1'b0;
                     state_in       = ST_RD;
                  end
                  ACT_RESTART: begin
                     mod_restart_in = 1'b1;
                     state_in       = ST_MOD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD: begin
            // The RAM holds its read data until the result register is free.
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_value_in     = refresh_ff ? fresh_ff : ram_rd_data;
               rsp_refreshed_in = refresh_ff;
               state_in         = refresh_ff ? ST_MOD : ST_IDLE;
            end
         end
         ST_MOD: begin
            if (!mod_status.busy) begin
               ptr_in = mod_rem[PTR_W-1:0];
               if (mod_restart_ff) begin
                  cursor_in = mod_rem[PTR_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      fresh_ff         <= fresh_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_refreshed_ff <= rsp_refreshed_in;
      refresh_ff       <= refresh_in;
      mod_restart_ff   <= mod_restart_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         ptr_ff       <= PTR_W'(1);
         ring_size_ff <= RING_SIZE_RESET;
         stride_ff    <= REPLACE_STRIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         ptr_ff       <= ptr_in;
         ring_size_ff <= ring_size_in;
         stride_ff    <= stride_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rrr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (EFF_MAX)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_fresh_value),
      .rd_en   (ram_rd_en),
      .rd_addr (cursor_eff),
      .rd_data (ram_rd_data)
   );

   rrr_mod #(
      .SUM_W (SUM_W),
      .NW    (NW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .modulus   (n_eff),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_refreshed = rsp_refreshed_ff;

   // After a draw the cursor must lie inside the ring that the draw saw.
   `RRR_ASSERT_NEXT(a_draw_cursor_in_ring, clock, reset, accept && (req_action == ACT_DRAW), SUM_W'(cursor_ff) < $past(n_ext), "cursor outside the ring after a draw")
   // Every draw passes through the read state that loads the result register.
   `RRR_ASSERT_NEXT(a_draw_enters_read, clock, reset, accept && (req_action == ACT_DRAW), state_ff == ST_RD, "draw did not enter the read state")
   // The remainder unit only finishes while the control is in the read or the remainder state.
   `RRR_ASSERT_SAME(a_mod_done_in_flight, clock, reset, mod_status.done, (state_ff == ST_MOD) || (state_ff == ST_RD), "remainder finished with no item waiting on it")

endmodule

>>> rtl/core/rrr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module rrr_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rrr_mod.sv
// Iterative shift-and-subtract remainder unit, one quotient bit per cycle.
module rrr_mod #(
   parameter int SUM_W = 11,
   parameter int NW    = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [SUM_W-1:0]            dividend,
   input  logic [NW-1:0]               modulus,
   output rrr_pkg::rrr_mod_status_type status,
   output logic [SUM_W-1:0]            remainder
);

   import rrr_pkg::*;

   localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
   localparam int WIDE_W = SUM_W + NW;

   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [NW-1:0]     mod_ff, mod_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [WIDE_W-1:0] shifted;
   logic [WIDE_W-1:0] rem_wide;
   logic [WIDE_W-1:0] diff;
   logic              take;

   always_comb begin
      shifted  = WIDE_W'(mod_ff) << step_ff;
      rem_wide = WIDE_W'(rem_ff);
      take     = rem_wide >= shifted;
      diff     = rem_wide - shifted;

      rem_in  = rem_ff;
      mod_in  = mod_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = dividend;
         mod_in  = modulus;
         step_in = STEP_W'(SUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the modulus shifted by the current step.
         if (take) begin
            rem_in = diff[SUM_W-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      mod_ff  <= mod_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the recycling random ring: directed, random and back-pressure runs.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rrr_pkg::*;

   localparam int RING_DEPTH = 1024;
   // A refreshing draw or a restart keeps the block busy on the remainder unit after its
   // request transfer; this margin covers that with room to spare.
   localparam int SETTLE_CYCLES = 40;
   // Longest correct quiet spell is the receiver hold-off, so this is generous.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 150;

   // Codes that the block accepts but must ignore.
   localparam logic [ACTION_W-1:0]  ACT_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               refreshed;
   } draw_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action = ACT_LOAD;
   logic [VALUE_W-1:0]    req_fresh_value = '0;
   logic [SLOT_W-1:0]     req_slot_index = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic                  rsp_refreshed;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RING_SIZE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state: the ring contents as the block should hold them, which slots
   // have ever been written, both pointers and the two registers.
   logic [VALUE_W-1:0]    ring_words [RING_DEPTH];
   bit                    slot_loaded [RING_DEPTH];
   logic [SLOT_W-1:0]     read_cursor = '0;
   logic [SLOT_W-1:0]     replace_ptr = 10'd1;
   logic [SIZE_W-1:0]     size_reg = RING_SIZE_RESET;
   logic [STRIDE_W-1:0]   stride_reg = REPLACE_STRIDE_RESET;

   // Draw results that have been predicted but not yet seen on the result channel.
   draw_result_type       expected_draws [$];

   int                    mismatches = 0;
   int                    results_seen = 0;
   int                    items_sent = 0;
   int                    draws_sent = 0;
   int                    refreshes_sent = 0;
   int                    csr_writes = 0;

   // Idling controls: the quiet flags switch the random gaps off on either side, and a
   // non-zero hold_left makes the receiver stall until it has counted down to zero.
   bit                    tx_quiet = 1'b0;
   bit                    rx_quiet = 1'b0;
   int                    hold_left = 0;
   int                    stall_left = 0;

   recycling_random_ring #(
      .RING_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_fresh_value (req_fresh_value),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_refreshed   (rsp_refreshed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #1 clock = ~clock;

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap(input bit quiet);
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Number of slots in use: a zero size counts as one slot, and anything above the
   // physical depth is clipped to it.
   function automatic int ring_span();
      int n;
      n = int'(size_reg);
      if (n == 0) begin
         n = 1;
      end
      if (n > RING_DEPTH) begin
         n = RING_DEPTH;
      end
      return n;
   endfunction

   // Applies one accepted request to the predicted ring and queues the draw result, if any.
   function automatic void apply_ring_item(input logic [ACTION_W-1:0] action,
                                           input logic [VALUE_W-1:0] fresh,
                                           input logic [SLOT_W-1:0] slot);
      int n;
      int next;
      draw_result_type res;
      n = ring_span();
      case (action)
         ACT_LOAD: begin
            // A load beyond the slots in use is dropped.
            if (int'(slot) < n) begin
               ring_words[slot] = fresh;
               slot_loaded[slot] = 1'b1;
            end
         end
         ACT_RESTART: begin
            read_cursor = SLOT_W'(int'(slot) % n);
            replace_ptr = read_cursor;
         end
         ACT_DRAW: begin
            // A cursor left beyond a shrunken ring wraps to the first slot before use.
            if (int'(read_cursor) >= n) begin
               read_cursor = '0;
            end
            res.refreshed = 1'b0;
            if (read_cursor == replace_ptr) begin
               ring_words[read_cursor] = fresh;
               slot_loaded[read_cursor] = 1'b1;
               res.refreshed = 1'b1;
               next = (int'(replace_ptr) + int'(stride_reg)) % n;
               replace_ptr = SLOT_W'(next);
               refreshes_sent++;
            end
            res.value = ring_words[read_cursor];
            next = int'(read_cursor) + 1;
            if (next >= n) begin
               next = 0;
            end
            read_cursor = SLOT_W'(next);
            expected_draws.push_back(res);
            draws_sent++;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                  input logic [VALUE_W-1:0] got);
      mismatches++;
      $display("%0t ns: draw result %0d, %s: expected %h, got %h",
               $time, results_seen, what, want, got);
   endtask

   // Offers one request after a random gap and holds it steady until the transfer
   // happens. The valid is left high afterwards, so that a following request with no
   // gap simply replaces the payload.
   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic [VALUE_W-1:0] fresh,
                            input logic [SLOT_W-1:0] slot);
      int gap;
      gap = pick_gap(tx_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_fresh_value <= fresh;
      req_slot_index <= slot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      apply_ring_item(action, fresh, slot);
      items_sent++;
   endtask

   // A draw that would read a slot never written is preceded by a load of that slot,
   // since the ring store holds no defined contents until written.
   task automatic draw_value(input logic [VALUE_W-1:0] fresh);
      int idx;
      logic [SLOT_W-1:0] slot;
      idx = (int'(read_cursor) >= ring_span()) ? 0 : int'(read_cursor);
      slot = SLOT_W'(idx);
      if (slot != replace_ptr && !slot_loaded[idx]) begin
         send_item(ACT_LOAD, $urandom(), slot);
      end
      send_item(ACT_DRAW, fresh, SLOT_W'($urandom_range(0, RING_DEPTH - 1)));
   endtask

   // Stops offering requests, waits until every predicted result has arrived and then
   // lets the block finish any restart or refresh still in progress.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_draws.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (index == CSR_RING_SIZE) begin
         size_reg = data;
      end else if (index == CSR_REPLACE_STRIDE) begin
         stride_reg = data[STRIDE_W-1:0];
      end
      csr_writes++;
   endtask

   task automatic send_random_item();
      int pick;
      int n;
      int run;
      logic [SLOT_W-1:0] slot;
      n = ring_span();
      pick = $urandom_range(0, 99);
      // Most slot indexes fall inside the ring; some range over the whole field.
      if ($urandom_range(0, 4) == 0) begin
         slot = SLOT_W'($urandom_range(0, RING_DEPTH - 1));
      end else begin
         slot = SLOT_W'($urandom_range(0, n - 1));
      end
      if (pick < 62) begin
         draw_value($urandom());
      end else if (pick < 77) begin
         send_item(ACT_LOAD, $urandom(), slot);
      end else if (pick < 86) begin
         send_item(ACT_RESTART, $urandom(), slot);
      end else if (pick < 92) begin
         send_item(ACT_UNUSED, $urandom(), slot);
      end else begin
         // A restart followed by a run of draws walks the refresh pattern from a
         // known starting point.
         send_item(ACT_RESTART, $urandom(), slot);
         run = $urandom_range(4, 16);
         repeat (run) draw_value($urandom());
      end
   endtask

   // Reset state and the extremes of every request field. Straight out of reset the
   // cursor sits one slot behind the replace pointer, so the first draw only reads
   // and the second refreshes; a restart at the top slot shows the wrap of both.
   task automatic test_defaults_and_extremes();
      send_item(ACT_LOAD, 32'h0000_0000, 10'd0);
      send_item(ACT_LOAD, 32'hFFFF_FFFF, 10'd1023);
      draw_value(32'h1234_5678);
      draw_value(32'hFFFF_FFFF);
      draw_value(32'hAAAA_AAAA);
      send_item(ACT_UNUSED, 32'hFFFF_FFFF, 10'h3FF);
      send_item(ACT_RESTART, 32'h5555_5555, 10'd1023);
      draw_value(32'h5555_5555);
      draw_value(32'h0000_0000);
      draw_value(32'hDEAD_BEEF);
      send_item(ACT_LOAD, 32'hAAAA_AAAA, 10'h2AA);
      send_item(ACT_LOAD, 32'h5555_5555, 10'h155);
      send_item(ACT_RESTART, 32'h0000_0000, 10'h155);
      draw_value(32'h0F0F_0F0F);
      draw_value(32'hF0F0_F0F0);
      send_item(ACT_UNUSED, 32'h0000_0000, 10'd0);
   endtask

   // Register extremes and the corner cases of the pointer arithmetic.
   task automatic test_size_extremes();
      // A zero size behaves as a single slot: every draw refreshes it, and indexes
      // beyond it are reduced or ignored.
      write_csr(CSR_RING_SIZE, 11'd0);
      send_item(ACT_RESTART, 32'h0, 10'd1023);
      send_item(ACT_LOAD, 32'hCAFE_F00D, 10'd5);
      repeat (3) draw_value($urandom());

      // Sizes above the physical depth clip to it; the stride register drops bit 10.
      write_csr(CSR_RING_SIZE, 11'h7FF);
      write_csr(CSR_REPLACE_STRIDE, 11'h7FF);
      send_item(ACT_RESTART, 32'h0, 10'd1000);
      repeat (3) draw_value($urandom());

      // Spare register indexes must leave both registers alone.
      write_csr(CSR_SPARE_LO, 11'h555);
      write_csr(CSR_SPARE_HI, 11'h2AA);

      // Shrinking the ring strands the cursor and the replace pointer beyond it: the
      // cursor wraps on the next draw, the pointer never matches until a restart.
      write_csr(CSR_RING_SIZE, 11'd5);
      repeat (6) draw_value($urandom());
      send_item(ACT_LOAD, 32'h1111_1111, 10'd7);
      send_item(ACT_RESTART, 32'h0, 10'd12);
      repeat (6) draw_value($urandom());

      // With a zero stride the same slot is refreshed on every lap of the cursor.
      write_csr(CSR_RING_SIZE, 11'd2);
      write_csr(CSR_REPLACE_STRIDE, 11'd0);
      send_item(ACT_RESTART, 32'h0, 10'd1);
      repeat (5) draw_value($urandom());

      // A stride well above the size advances by its remainder.
      write_csr(CSR_RING_SIZE, 11'd10);
      write_csr(CSR_REPLACE_STRIDE, 11'd1023);
      send_item(ACT_RESTART, 32'h0, 10'd3);
      repeat (12) draw_value($urandom());
   endtask

   // Phases of random traffic, each under a fresh pair of register values. Sizes are
   // mostly small so that the cursor laps the ring often; one phase runs with no
   // idling on either side.
   task automatic test_random_traffic();
      int phase;
      int pick;
      int n;
      int target;
      logic [SIZE_W-1:0] size_data;
      logic [CSR_DATA_W-1:0] stride_data;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            size_data = SIZE_W'($urandom_range(2, 40));
         end else if (pick < 8) begin
            size_data = SIZE_W'($urandom_range(41, RING_DEPTH));
         end else begin
            size_data = SIZE_W'($urandom_range(0, SIZE_MAX));
         end
         write_csr(CSR_RING_SIZE, size_data);
         n = ring_span();
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            stride_data = (n > 1) ? CSR_DATA_W'($urandom_range(1, n - 1)) : '0;
         end else if (pick < 8) begin
            stride_data = '0;
         end else begin
            stride_data = CSR_DATA_W'($urandom_range(0, 2047));
         end
         write_csr(CSR_REPLACE_STRIDE, stride_data);
         tx_quiet = (phase == 3);
         rx_quiet = (phase == 3);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            send_random_item();
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering draws
   // back to back, so the block fills up and stalls its request channel. Afterwards
   // the sender waits for every outstanding result before carrying on.
   task automatic test_back_pressure();
      hold_left = HOLD_OFF_CYCLES;
      tx_quiet = 1'b1;
      repeat (64) draw_value($urandom());
      tx_quiet = 1'b0;
      wait_drained();
      repeat (100) send_random_item();
   endtask

   // Receiver: one stall decision per cycle, either from a requested hold-off or from
   // a randomly chosen run of stalled cycles.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap(rx_quiet);
      end
   end

   // Each result transfer is compared with the oldest predicted draw.
   always @(posedge clock) begin : check_results
      draw_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_draws.size() == 0) begin
            report_mismatch("result with none expected", '0, rsp_value);
         end else begin
            want = expected_draws.pop_front();
            if (rsp_value !== want.value) begin
               report_mismatch("value", want.value, rsp_value);
            end
            if (rsp_refreshed !== want.refreshed) begin
               report_mismatch("refreshed", VALUE_W'(want.refreshed),
                               VALUE_W'(rsp_refreshed));
            end
         end
      end
   end

   // Watchdog: too long without any transfer on any channel means the block hung.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_draws.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults_and_extremes();
      test_size_extremes();
      test_random_traffic();
      test_back_pressure();
      wait_drained();
      $display("Covered %0d request transfers: %0d draws, %0d of them refreshing a slot,",
               items_sent, draws_sent, refreshes_sent);
      $display("and %0d register writes; %0d results checked, %0d mismatches.",
               csr_writes, results_seen, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
